// ===== rtl/core/twq_pkg.sv =====
// Package for the timed wait queue: item kinds, status codes, payload structs.
// No dependencies.
package twq_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  task_id;
    logic [31:0] wake_time;
    logic [7:0]  task_priority;
    logic [31:0] tick_time;
    logic [7:0]  running_priority;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       woken_valid;
    logic [5:0] woken_id;
    logic [5:0] chosen_id;
    logic       preempt;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_EMIT
  } bk_state_t;

endpackage

// ===== rtl/core/twq_if.sv =====
// Valid/ready channel interfaces for the wait queue.
// Depends on twq_pkg.
interface twq_in_if;
  logic              valid;
  logic              ready;
  twq_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface twq_out_if;
  logic               valid;
  logic               ready;
  twq_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/timed_wait_queue_with_wakeup_preempt_top.sv =====
// Timed wait queue top level: front queue plus sorted store back end.
// The back end takes a request from the front queue only while idle, scans the store
// for it, passing at most QUEUE_DEPTH entries, and registers the first result.
// A tick that wakes n tasks then gives one result per cycle for n - 1 more while the receiver is ready.
// The back end takes no new request before it is through with the last, so the scan sets the rate.
// Reset (rst_n low, synchronous) empties the store, the front queue and the result register.
module timed_wait_queue_with_wakeup_preempt_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_COUNT    = 64
) (
  input logic    clk,
  input logic    rst_n,
  twq_in_if.sink    in_ch,
  twq_out_if.source out_ch
);
  logic q_valid, q_pop;
  twq_pkg::in_item_t q_data;

  twq_front #(.ID_COUNT(ID_COUNT)) u_front (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .q_valid, .q_pop, .q_data
  );

  twq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_data,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );
endmodule

// ===== rtl/core/twq_front.sv =====
// Front part: accepts requests, normalizes the kind and holds a two-entry queue.
// Depends on twq_pkg.
module twq_front #(
  parameter int ID_COUNT = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  twq_pkg::in_item_t  in_data,
  output logic               q_valid,
  input  logic               q_pop,
  output twq_pkg::in_item_t  q_data
);
  twq_pkg::in_item_t buf_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  twq_pkg::in_item_t cls;
  logic push;

  // Inserts of ids beyond the id range do nothing, so they become empty requests.
  always_comb begin
    cls = in_data;
    if (in_data.kind == twq_pkg::KIND_INSERT && 32'(in_data.task_id) >= 32'(ID_COUNT))
      cls.kind = twq_pkg::KIND_NONE;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = buf_r[rd_r];
  assign cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, q_pop && q_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= ~wr_r;
      if (q_pop && q_valid) rd_r <= ~rd_r;
    end
    if (push) buf_r[wr_r] <= cls;
  end
endmodule

// ===== rtl/core/twq_back.sv =====
// Back part: sorted store in shift registers, scanned one entry per cycle.
// Depends on twq_pkg.
module twq_back #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  twq_pkg::in_item_t  q_data,
  output logic               out_valid,
  input  logic               out_ready,
  output twq_pkg::out_item_t out_data
);
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [5:0]  ids_r  [QUEUE_DEPTH];
  logic [31:0] wts_r  [QUEUE_DEPTH];
  logic [7:0]  prs_r  [QUEUE_DEPTH];
  logic [CW-1:0] count_r;

  twq_pkg::bk_state_t st_r, st_nxt;
  twq_pkg::in_item_t  cur_r;
  logic [CW-1:0] pos_r;
  logic [5:0]    bestid_r;
  logic [7:0]    bestp_r;
  logic [CW-1:0] n_r;
  logic [CW-1:0] ei_r;
  logic          ov_r;
  twq_pkg::out_item_t od_r;

  logic [IW-1:0] pi;
  logic in_range, stop, commit;
  assign pi       = pos_r[IW-1:0];
  assign in_range = (pos_r < count_r);
  assign q_pop    = (st_r == twq_pkg::BK_IDLE) && q_valid;

  // Scan ends at the first entry that fails the kind's condition.
  always_comb begin
    stop = !in_range;
    if (in_range) begin
      case (cur_r.kind)
        twq_pkg::KIND_INSERT: stop = !(cur_r.wake_time > wts_r[pi]);
        twq_pkg::KIND_REMOVE: stop = (ids_r[pi] == cur_r.task_id);
        twq_pkg::KIND_TICK:   stop = !(wts_r[pi] <= cur_r.tick_time);
        default:              stop = 1'b1;
      endcase
    end
  end

  logic free;
  assign free   = !ov_r || out_ready;
  assign commit = (st_r == twq_pkg::BK_SCAN) && stop && free;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      twq_pkg::BK_IDLE: if (q_valid) st_nxt = twq_pkg::BK_SCAN;
      twq_pkg::BK_SCAN: begin
        if (commit) begin
          if (cur_r.kind == twq_pkg::KIND_TICK && pos_r > 1) st_nxt = twq_pkg::BK_EMIT;
          else st_nxt = twq_pkg::BK_IDLE;
        end
      end
      twq_pkg::BK_EMIT: if (free && ei_r + 1'b1 == n_r) st_nxt = twq_pkg::BK_IDLE;
      default: st_nxt = twq_pkg::BK_IDLE;
    endcase
  end

  // Tick results come from the head; the store shifts one place per result.
  twq_pkg::out_item_t res;
  always_comb begin
    res = '0;
    unique case (st_r)
      twq_pkg::BK_SCAN: begin
        res.last = (cur_r.kind != twq_pkg::KIND_TICK) || (pos_r <= 1);
        case (cur_r.kind)
          twq_pkg::KIND_INSERT:
            res.status = (count_r == CW'(QUEUE_DEPTH)) ? twq_pkg::ST_FULL : twq_pkg::ST_OK;
          twq_pkg::KIND_REMOVE:
            res.status = in_range ? twq_pkg::ST_OK : twq_pkg::ST_NOT_FOUND;
          twq_pkg::KIND_TICK: begin
            if (pos_r != 0) begin
              res.woken_valid = 1'b1;
              res.woken_id    = ids_r[0];
              if (pos_r == 1) begin
                res.chosen_id = ids_r[0];
                res.preempt   = prs_r[0] > cur_r.running_priority;
              end
            end
          end
          default: ;
        endcase
      end
      twq_pkg::BK_EMIT: begin
        res.woken_valid = 1'b1;
        res.woken_id    = ids_r[0];
        res.last        = (ei_r + 1'b1 == n_r);
        if (res.last) begin
          res.chosen_id = bestid_r;
          res.preempt   = bestp_r > cur_r.running_priority;
        end
      end
      default: ;
    endcase
  end

  logic shift_head;
  assign shift_head = (st_r == twq_pkg::BK_EMIT && free) ||
                      (commit && cur_r.kind == twq_pkg::KIND_TICK && pos_r != 0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= twq_pkg::BK_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (commit || (st_r == twq_pkg::BK_EMIT && free)) ov_r <= 1'b1;
      else if (ov_r && out_ready) ov_r <= 1'b0;
      if (commit && cur_r.kind == twq_pkg::KIND_INSERT && count_r != CW'(QUEUE_DEPTH))
        count_r <= count_r + 1'b1;
      else if ((commit && cur_r.kind == twq_pkg::KIND_REMOVE && in_range) || shift_head)
        count_r <= count_r - 1'b1;
    end
    if (commit || (st_r == twq_pkg::BK_EMIT && free)) od_r <= res;
    // The first tick result leaves at commit, so emission counts from one.
    if (q_pop) begin
      cur_r    <= q_data;
      pos_r    <= '0;
      bestid_r <= '0;
      bestp_r  <= '0;
      ei_r     <= CW'(1);
    end else if (st_r == twq_pkg::BK_SCAN && !stop) begin
      pos_r <= pos_r + 1'b1;
      if (cur_r.kind == twq_pkg::KIND_TICK && (pos_r == 0 || bestp_r < prs_r[pi])) begin
        bestid_r <= ids_r[pi];
        bestp_r  <= prs_r[pi];
      end
    end else if (st_r == twq_pkg::BK_EMIT && free) begin
      ei_r <= ei_r + 1'b1;
    end
    if (commit) n_r <= pos_r;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (commit && cur_r.kind == twq_pkg::KIND_INSERT && count_r != CW'(QUEUE_DEPTH)) begin
        if (IW'(i) == pi && CW'(i) == pos_r) begin
          ids_r[i] <= cur_r.task_id;
          wts_r[i] <= cur_r.wake_time;
          prs_r[i] <= cur_r.task_priority;
        end else if (CW'(i) > pos_r) begin
          ids_r[i] <= ids_r[(i+QUEUE_DEPTH-1) % QUEUE_DEPTH];
          wts_r[i] <= wts_r[(i+QUEUE_DEPTH-1) % QUEUE_DEPTH];
          prs_r[i] <= prs_r[(i+QUEUE_DEPTH-1) % QUEUE_DEPTH];
        end
      end else if ((commit && cur_r.kind == twq_pkg::KIND_REMOVE && in_range
                    && CW'(i) >= pos_r) || shift_head) begin
        if (i + 1 < QUEUE_DEPTH) begin
          ids_r[i] <= ids_r[(i+1) % QUEUE_DEPTH];
          wts_r[i] <= wts_r[(i+1) % QUEUE_DEPTH];
          prs_r[i] <= prs_r[(i+1) % QUEUE_DEPTH];
        end
      end
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count beyond depth");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |=> ov_r && $stable(od_r)) else $error("result dropped");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> st_r == twq_pkg::BK_SCAN) else $error("pop outside idle");
endmodule

// ===== sim/tb_timed_wait_queue_with_wakeup_preempt_top.sv =====
// Testbench for the timed wait queue: a scoreboard class predicts every result
// from its own copy of the sorted store. Depends on twq_pkg, twq_if and the RTL.
`timescale 1ns / 1ps

module tb_timed_wait_queue_with_wakeup_preempt_top;

  localparam int DEPTH = 16;

  class wait_queue_scoreboard;
    logic [5:0]  ids [DEPTH];
    logic [31:0] wakes [DEPTH];
    logic [7:0]  prios [DEPTH];
    int          count;
    twq_pkg::out_item_t pending_results [$];
    int          errors;
    int          results_seen;
    int          woken_seen;
    int          full_seen;
    int          missing_seen;

    function new();
      count = 0;
      errors = 0;
      results_seen = 0;
      woken_seen = 0;
      full_seen = 0;
      missing_seen = 0;
    endfunction

    function twq_pkg::out_item_t blank_result();
      twq_pkg::out_item_t r;
      r = '0;
      r.status = twq_pkg::ST_OK;
      r.last = 1'b1;
      return r;
    endfunction

    function void note_request(twq_pkg::in_item_t req);
      twq_pkg::out_item_t r;
      int pos;
      int n;
      int best;
      r = blank_result();
      case (req.kind)
        twq_pkg::KIND_INSERT: begin
          if (count >= DEPTH) begin
            r.status = twq_pkg::ST_FULL;
            full_seen++;
          end else begin
            pos = 0;
            while (pos < count && req.wake_time > wakes[pos]) pos++;
            for (int i = count; i > pos; i--) begin
              ids[i] = ids[i-1];
              wakes[i] = wakes[i-1];
              prios[i] = prios[i-1];
            end
            ids[pos] = req.task_id;
            wakes[pos] = req.wake_time;
            prios[pos] = req.task_priority;
            count++;
          end
          pending_results.push_back(r);
        end
        twq_pkg::KIND_REMOVE: begin
          pos = 0;
          while (pos < count && ids[pos] != req.task_id) pos++;
          if (pos >= count) begin
            r.status = twq_pkg::ST_NOT_FOUND;
            missing_seen++;
          end else begin
            for (int i = pos; i + 1 < count; i++) begin
              ids[i] = ids[i+1];
              wakes[i] = wakes[i+1];
              prios[i] = prios[i+1];
            end
            count--;
          end
          pending_results.push_back(r);
        end
        twq_pkg::KIND_TICK: begin
          n = 0;
          best = 0;
          while (n < count && wakes[n] <= req.tick_time) begin
            if (n == 0 || prios[best] < prios[n]) best = n;
            n++;
          end
          if (n == 0) begin
            pending_results.push_back(r);
          end else begin
            for (int i = 0; i < n; i++) begin
              r = '0;
              r.status = twq_pkg::ST_OK;
              r.woken_valid = 1'b1;
              r.woken_id = ids[i];
              if (i + 1 == n) begin
                r.last = 1'b1;
                r.chosen_id = ids[best];
                r.preempt = prios[best] > req.running_priority;
              end
              pending_results.push_back(r);
            end
            for (int i = 0; i + n < count; i++) begin
              ids[i] = ids[i+n];
              wakes[i] = wakes[i+n];
              prios[i] = prios[i+n];
            end
            count -= n;
            woken_seen += n;
          end
        end
        default: pending_results.push_back(r);
      endcase
    endfunction

    function void check_result(twq_pkg::out_item_t got);
      twq_pkg::out_item_t exp;
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (got.status !== exp.status)
        $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
      if (got.woken_valid !== exp.woken_valid)
        $display("%0t: woken_valid exp %0d got %0d", $time, exp.woken_valid, got.woken_valid);
      if (got.woken_id !== exp.woken_id)
        $display("%0t: woken_id exp %0d got %0d", $time, exp.woken_id, got.woken_id);
      if (got.chosen_id !== exp.chosen_id)
        $display("%0t: chosen_id exp %0d got %0d", $time, exp.chosen_id, got.chosen_id);
      if (got.preempt !== exp.preempt)
        $display("%0t: preempt exp %0d got %0d", $time, exp.preempt, got.preempt);
      if (got.last !== exp.last)
        $display("%0t: last exp %0d got %0d", $time, exp.last, got.last);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  twq_in_if  in_ch ();
  twq_out_if out_ch ();

  timed_wait_queue_with_wakeup_preempt_top #(
    .QUEUE_DEPTH(DEPTH),
    .ID_COUNT   (64)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  wait_queue_scoreboard sb;
  bit          long_hold;
  logic [31:0] now;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("timed_wait_queue_with_wakeup_preempt_top regression: fail");
    $finish;
  end

  // Result side: random stall per result, plus one long hold-off on request.
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  task automatic send_request(twq_pkg::in_item_t req);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.data <= req;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(req);
  endtask

  function automatic twq_pkg::in_item_t noise_item(twq_pkg::kind_t k);
    twq_pkg::in_item_t r;
    r.kind = k;
    r.task_id = 6'($urandom);
    r.wake_time = $urandom;
    r.task_priority = 8'($urandom);
    r.tick_time = $urandom;
    r.running_priority = 8'($urandom);
    return r;
  endfunction

  task automatic insert_task(logic [5:0] id, logic [31:0] wt, logic [7:0] pr);
    twq_pkg::in_item_t r;
    r = noise_item(twq_pkg::KIND_INSERT);
    r.task_id = id;
    r.wake_time = wt;
    r.task_priority = pr;
    send_request(r);
  endtask

  task automatic remove_task(logic [5:0] id);
    twq_pkg::in_item_t r;
    r = noise_item(twq_pkg::KIND_REMOVE);
    r.task_id = id;
    send_request(r);
  endtask

  task automatic tick(logic [31:0] t, logic [7:0] running);
    twq_pkg::in_item_t r;
    r = noise_item(twq_pkg::KIND_TICK);
    r.tick_time = t;
    r.running_priority = running;
    send_request(r);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  initial begin
    int sel;
    sb = new();
    long_hold = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty tick, missing id, extremes, duplicates, full store.
    tick(32'hFFFF_FFFF, 8'd0);
    remove_task(6'd63);
    insert_task(6'd0, 32'd0, 8'd0);
    insert_task(6'd63, 32'hFFFF_FFFF, 8'd255);
    insert_task(6'd5, 32'd100, 8'd7);
    insert_task(6'd5, 32'd100, 8'd7);
    insert_task(6'd9, 32'd100, 8'd7);
    remove_task(6'd5);
    send_request(noise_item(twq_pkg::KIND_NONE));
    tick(32'd100, 8'd7);
    tick(32'd50, 8'd0);
    for (int i = 0; i < 16; i++) insert_task(6'(i + 20), 32'd200 + (i % 3), 8'(i % 4));
    insert_task(6'd1, 32'd1, 8'd1);
    tick(32'hFFFF_FFFE, 8'd2);
    tick(32'hFFFF_FFFF, 8'd255);
    drain();

    // Receiver holds off while requests keep arriving, so the block backs up.
    long_hold = 1'b1;
    now = 32'd1000;
    for (int i = 0; i < 16; i++)
      insert_task(6'($urandom), now + $urandom_range(0, 50), 8'($urandom));
    tick(now + 60, 8'($urandom));
    for (int i = 0; i < 4; i++) tick(now + 60, 8'($urandom));
    drain();

    now = $urandom;
    for (int i = 0; i < 110; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        if ($urandom_range(0, 9) == 0)
          insert_task(6'($urandom), $urandom, 8'($urandom));
        else
          insert_task(6'($urandom), now + $urandom_range(0, 400), 8'($urandom));
      end else if (sel < 65) begin
        if (sb.count > 0 && $urandom_range(0, 3) != 0)
          remove_task(sb.ids[$urandom_range(0, sb.count - 1)]);
        else
          remove_task(6'($urandom));
      end else if (sel < 95) begin
        now = now + $urandom_range(0, 200);
        if ($urandom_range(0, 15) == 0) tick($urandom, 8'($urandom));
        else tick(now, 8'($urandom));
      end else begin
        send_request(noise_item(twq_pkg::KIND_NONE));
      end
      if (i == 55) drain();
    end
    drain();

    $display("Covered %0d results, %0d woken tasks, %0d full and %0d missing-id replies.",
             sb.results_seen, sb.woken_seen, sb.full_seen, sb.missing_seen);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("timed_wait_queue_with_wakeup_preempt_top regression: pass");
    end else begin
      $display("timed_wait_queue_with_wakeup_preempt_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/twq_pkg.sv
rtl/core/twq_if.sv
rtl/core/twq_front.sv
rtl/core/twq_back.sv
rtl/core/timed_wait_queue_with_wakeup_preempt_top.sv
sim/tb_timed_wait_queue_with_wakeup_preempt_top.sv
